[hw/rtl/ipi_mailbox_sync_region_defines.svh]
// assertion macros for the ipi mailbox sync region
`ifndef IPI_MAILBOX_SYNC_REGION_DEFINES_SVH
`define IPI_MAILBOX_SYNC_REGION_DEFINES_SVH

// same-cycle implication, checked out of reset
`define IPIMB_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define IPIMB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/ipimb_pkg.sv]
// types and constants for the ipi mailbox sync region
package ipimb_pkg;

    localparam int REGION_BYTES = 64;
    localparam int REGION_WORDS = 16;

    localparam logic [3:0] W_ITEM   = 4'd1;
    localparam logic [3:0] W_READY  = 4'd2;
    localparam logic [3:0] W_DONE   = 4'd3;
    localparam logic [3:0] W_NHARTS = 4'd4;

    localparam logic [2:0] CMD_REGION_WR = 3'd0;
    localparam logic [2:0] CMD_REGION_RD = 3'd1;
    localparam logic [2:0] CMD_DOORBELL_WR = 3'd2;
    localparam logic [2:0] CMD_DOORBELL_RD = 3'd3;
    localparam logic [2:0] CMD_COUNTER_ST = 3'd4;
    localparam logic [2:0] CMD_INIT = 3'd5;

    localparam logic [2:0] SIZE_BYTE = 3'd1;
    localparam logic [2:0] SIZE_HALF = 3'd2;
    localparam logic [2:0] SIZE_WORD = 3'd4;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [5:0]  byte_offset;
        logic [2:0]  access_size;
        logic [31:0] write_data;
        logic [2:0]  source_hart;
    } t_in_word;

    typedef struct packed {
        logic [31:0] read_data;
        logic        accepted;
        logic        ipi_sent;
        logic [2:0]  ipi_target;
    } t_out_word;

    typedef enum logic [3:0] {
        S_IDLE,
        S_BYTE_RD,
        S_BYTE_UPD,
        S_DB_RD,
        S_DB_CAP,
        S_DIV,
        S_DLV_CHK,
        S_DLV_ITEM,
        S_DLV_READY,
        S_DLV_PEND,
        S_INIT,
        S_FIN
    } t_state;

endpackage

[hw/rtl/ipi_mailbox_sync_region.sv]
// ipi mailbox over a 64-byte shared sync region, top level
// One word is taken at a time; the input stalls from acceptance until the result is
// loaded into the output register, which can then wait while the next word is taken.
// Region reads and writes work one byte at a time: a read of the word store, then a merge
// and write back, or for a read the capture of the byte; a rejected access ends at once.
// A doorbell read reads the done word and captures it; init clears the valid bits.
// A round-robin doorbell or counter store runs a bit-serial remainder unit and then
// writes item, ready and pending flag through the single write port of the word
// store when it delivers; a doorbell with an explicit target skips the remainder unit.
// A stalled output register holds the result in the final state. The sync words sit
// in a 16-entry store with one read and one write port, each entry with a valid bit
// cleared by reset and by init, which then marks only the hart count word valid.
`include "ipi_mailbox_sync_region_defines.svh"

module ipi_mailbox_sync_region
    import ipimb_pkg::*;
#(
    parameter int MAX_HARTS         = 8,
    parameter int PENDING_BASE_WORD = 5
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic [3:0] i_cfg_wdata,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    t_state r_state, n_state;

    logic [3:0]  r_hart_count;
    logic [31:0] r_mem [REGION_WORDS];
    logic [REGION_WORDS-1:0] r_valid;
    logic [31:0] r_rdata;

    logic [2:0]  r_cmd;
    logic [5:0]  r_pos;
    logic [1:0]  r_idx;
    logic [2:0]  r_size;
    logic [31:0] r_data;
    logic [31:0] r_item;
    logic [31:0] r_div;
    logic [3:0]  r_rem;
    logic [4:0]  r_cnt;
    logic [7:0]  r_tgt;
    logic [31:0] r_rd;
    logic        r_acc;

    logic        r_out_valid;
    t_out_word   r_out;

    logic        accept;
    logic [3:0]  eff_harts;
    logic        have_worker;
    logic [3:0]  divisor;
    logic [4:0]  div_shift;
    logic [4:0]  div_sub;
    logic [3:0]  rem_next;
    logic        size_ok;
    logic [6:0]  end_byte;
    logic        region_ok;
    logic        last_byte;
    logic [8:0]  pend_sum;
    logic        dlv_ok;
    logic [7:0]  rd_byte;
    logic [31:0] merged;
    logic        out_free;

    logic        mem_we;
    logic [3:0]  mem_waddr;
    logic [31:0] mem_wdata;
    logic        mem_init;
    logic [3:0]  mem_raddr;
    logic        out_load;

    assign accept      = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;
    assign out_free    = !r_out_valid || !i_out_stall;

    assign eff_harts   = (r_hart_count > 4'(MAX_HARTS)) ? 4'(MAX_HARTS) : r_hart_count;
    assign have_worker = (eff_harts >= 4'd2);
    assign divisor     = eff_harts - 4'd1;

    // restoring remainder step
    assign div_shift = {r_rem, r_div[31]};
    assign div_sub   = div_shift - {1'b0, divisor};
    assign rem_next  = (div_shift >= {1'b0, divisor}) ? div_sub[3:0] : div_shift[3:0];

    assign size_ok   = (i_in_word.access_size == SIZE_BYTE)
                    || (i_in_word.access_size == SIZE_HALF)
                    || (i_in_word.access_size == SIZE_WORD);
    assign end_byte  = {1'b0, i_in_word.byte_offset} + {4'b0, i_in_word.access_size};
    assign region_ok = size_ok && (end_byte <= 7'(REGION_BYTES));
    assign last_byte = (({1'b0, r_idx} + 3'd1) == r_size);

    assign pend_sum  = 9'(PENDING_BASE_WORD) + {1'b0, r_tgt};
    assign dlv_ok    = (r_tgt != 8'd0) && (r_tgt < {4'b0, eff_harts})
                    && (pend_sum < 9'(REGION_WORDS));

    assign rd_byte = r_rdata[8*r_pos[1:0] +: 8];
    always_comb begin
        merged = r_rdata;
        merged[8*r_pos[1:0] +: 8] = r_data[7:0];
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_in_word.cmd) inside
                        CMD_REGION_WR, CMD_REGION_RD:
                            n_state = region_ok ? S_BYTE_RD : S_FIN;
                        CMD_DOORBELL_WR: begin
                            if (i_in_word.access_size != SIZE_WORD) begin
                                n_state = S_FIN;
                            end else if (i_in_word.write_data[23:16] != 8'd0) begin
                                n_state = S_DLV_CHK;
                            end else begin
                                n_state = have_worker ? S_DIV : S_FIN;
                            end
                        end
                        CMD_DOORBELL_RD: n_state = S_DB_RD;
                        CMD_COUNTER_ST:
                            n_state = (i_in_word.source_hart == 3'd0 && have_worker)
                                    ? S_DIV : S_FIN;
                        CMD_INIT: n_state = S_INIT;
                        default:  n_state = S_FIN;
                    endcase
                end
            end
            S_BYTE_RD:   n_state = S_BYTE_UPD;
            S_BYTE_UPD:  n_state = last_byte ? S_FIN : S_BYTE_RD;
            S_DB_RD:     n_state = S_DB_CAP;
            S_DB_CAP:    n_state = S_FIN;
            S_DIV:       n_state = (r_cnt == 5'd31) ? S_DLV_CHK : S_DIV;
            S_DLV_CHK:   n_state = dlv_ok ? S_DLV_ITEM : S_FIN;
            S_DLV_ITEM:  n_state = S_DLV_READY;
            S_DLV_READY: n_state = S_DLV_PEND;
            S_DLV_PEND:  n_state = S_FIN;
            S_INIT:      n_state = S_FIN;
            S_FIN:       n_state = out_free ? S_IDLE : S_FIN;
            default:     n_state = S_IDLE;
        endcase
    end

    // store port controls
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = W_ITEM;
        mem_wdata = r_item;
        mem_init  = 1'b0;
        mem_raddr = r_pos[5:2];
        out_load  = 1'b0;
        unique case (r_state)
            S_BYTE_UPD: begin
                mem_we    = (r_cmd == CMD_REGION_WR);
                mem_waddr = r_pos[5:2];
                mem_wdata = merged;
            end
            S_DB_RD:     mem_raddr = W_DONE;
            S_DLV_ITEM: begin
                mem_we    = 1'b1;
                mem_waddr = W_ITEM;
                mem_wdata = r_item;
            end
            S_DLV_READY: begin
                mem_we    = 1'b1;
                mem_waddr = W_READY;
                mem_wdata = 32'd1;
            end
            S_DLV_PEND: begin
                mem_we    = 1'b1;
                mem_waddr = pend_sum[3:0];
                mem_wdata = 32'd1;
            end
            S_INIT: begin
                mem_init  = 1'b1;
                mem_waddr = W_NHARTS;
                mem_wdata = {28'd0, r_hart_count};
            end
            S_FIN:       out_load = out_free;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_hart_count <= 4'd1;
            r_valid      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_hart_count <= i_cfg_wdata;
            end
            if (mem_init) begin
                r_valid <= {{(REGION_WORDS-1){1'b0}}, 1'b1} << W_NHARTS;
            end else if (mem_we) begin
                r_valid[mem_waddr] <= 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // word store
    always_ff @(posedge i_clk) begin
        if (mem_we || mem_init) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_valid[mem_raddr] ? r_mem[mem_raddr] : 32'd0;
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.read_data  <= r_rd;
            r_out.accepted   <= r_acc;
            r_out.ipi_sent   <= (r_tgt != 8'd0);
            r_out.ipi_target <= r_tgt[2:0];
        end
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_cmd  <= i_in_word.cmd;
                    r_pos  <= i_in_word.byte_offset;
                    r_idx  <= 2'd0;
                    r_size <= i_in_word.access_size;
                    r_data <= i_in_word.write_data;
                    r_rem  <= 4'd0;
                    r_cnt  <= 5'd0;
                    r_rd   <= 32'd0;
                    if (i_in_word.cmd == CMD_DOORBELL_WR) begin
                        r_item <= {16'd0, i_in_word.write_data[15:0]};
                        r_div  <= {16'd0, i_in_word.write_data[15:0]};
                        r_tgt  <= (i_in_word.access_size == SIZE_WORD)
                                ? i_in_word.write_data[23:16] : 8'd0;
                    end else begin
                        r_item <= i_in_word.write_data;
                        r_div  <= i_in_word.write_data;
                        r_tgt  <= 8'd0;
                    end
                    unique case (i_in_word.cmd) inside
                        CMD_REGION_WR, CMD_REGION_RD: r_acc <= region_ok;
                        CMD_DOORBELL_WR: r_acc <= (i_in_word.access_size == SIZE_WORD);
                        CMD_DOORBELL_RD, CMD_COUNTER_ST, CMD_INIT: r_acc <= 1'b1;
                        default: r_acc <= 1'b0;
                    endcase
                end
            end
            S_BYTE_UPD: begin
                if (r_cmd == CMD_REGION_RD) begin
                    r_rd[8*r_idx +: 8] <= rd_byte;
                end
                r_pos  <= r_pos + 6'd1;
                r_idx  <= r_idx + 2'd1;
                r_data <= {8'd0, r_data[31:8]};
            end
            S_DB_CAP: r_rd <= r_rdata;
            S_DIV: begin
                r_rem <= rem_next;
                r_div <= {r_div[30:0], 1'b0};
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_tgt <= {4'd0, rem_next} + 8'd1;
                end
            end
            S_DLV_CHK: begin
                if (!dlv_ok) begin
                    r_tgt <= 8'd0;
                end
            end
            default: begin
            end
        endcase
    end

    `IPIMB_ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, accept, r_state != S_IDLE, "accepted word left sequencer idle")
    `IPIMB_ASSERT_NOW(a_rem_below_divisor, i_clk, i_rst_n, r_state == S_DIV, r_rem < divisor, "remainder not below divisor")
    `IPIMB_ASSERT_NOW(a_sent_needs_accept, i_clk, i_rst_n, o_out_valid && o_out_word.ipi_sent, o_out_word.accepted, "interrupt on rejected word")
    `IPIMB_ASSERT_NOW(a_no_target_unsent, i_clk, i_rst_n, o_out_valid && !o_out_word.ipi_sent, o_out_word.ipi_target == 3'd0, "target without interrupt")
    `IPIMB_ASSERT_NOW(a_data_needs_accept, i_clk, i_rst_n, o_out_valid && (o_out_word.read_data != 32'd0), o_out_word.accepted, "read data on rejected word")

endmodule

[dv/ipi_mailbox_sync_region_tb.sv]
// self-checking testbench for the ipi mailbox sync region: directed table, then random accesses
module ipi_mailbox_sync_region_tb
    import ipimb_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_HARTS         = 8;
    localparam int PENDING_BASE_WORD = 5;
    localparam int PHASES            = 7;
    localparam int ITEMS_PER_PHASE   = 72;
    localparam int LONG_HOLD         = 300;
    localparam int STALL_LIMIT       = 2000;
    localparam int TAIL_CYCLES       = 60;
    localparam int MAX_REPORTS       = 40;

    localparam logic [2:0] CMD_RSVD_6 = 3'd6;
    localparam logic [2:0] CMD_RSVD_7 = 3'd7;
    localparam logic [2:0] SIZE_NONE  = 3'd0;
    localparam logic [2:0] SIZE_ODD   = 3'd3;

    typedef struct packed {
        bit         set_harts;
        logic [3:0] harts;
        t_in_word   word;
        bit         typed;
        t_out_word  result;
    } t_stim_row;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_cfg_we    = 1'b0;
    logic [3:0] i_cfg_wdata = 4'd0;
    logic       i_in_valid  = 1'b0;
    t_in_word   i_in_word   = '0;
    logic       i_out_stall = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    t_out_word  o_out_word;

    ipi_mailbox_sync_region #(
        .MAX_HARTS(MAX_HARTS),
        .PENDING_BASE_WORD(PENDING_BASE_WORD)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_in_word(i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_word(o_out_word)
    );

    always #1 i_clk = ~i_clk;

    // mirror of the sync region and the hart count register
    logic [31:0] region_words [16];
    logic [3:0]  harts_cfg;

    t_out_word   due_words [$];
    t_stim_row   directed [$];
    t_out_word   due;
    bit          row_typed;
    t_out_word   row_result;
    bit          long_hold_req = 1'b0;
    bit          no_idle = 1'b0;
    int unsigned stall_left = 0;
    int unsigned quiet_cycles = 0;
    int unsigned fail_count = 0;
    logic [3:0]  phase_harts [PHASES];

    function automatic int unsigned live_harts();
        return (harts_cfg > MAX_HARTS) ? MAX_HARTS : harts_cfg;
    endfunction

    function automatic int unsigned worker_for(logic [31:0] item);
        int unsigned h;
        h = live_harts();
        if (h < 2) return 0;
        return item % (h - 1) + 1;
    endfunction

    function automatic int unsigned post_work(int unsigned target, logic [31:0] item);
        if (target == 0 || target >= live_harts() || PENDING_BASE_WORD + target >= REGION_WORDS)
            return 0;
        region_words[W_ITEM]  = item;
        region_words[W_READY] = 32'd1;
        region_words[PENDING_BASE_WORD + target] = 32'd1;
        return target;
    endfunction

    function automatic t_out_word mailbox_step(t_in_word w);
        t_out_word   r;
        int          pos;
        int unsigned target;
        bit          legal;
        r = '0;
        target = 0;
        legal = (w.access_size == SIZE_BYTE || w.access_size == SIZE_HALF ||
                 w.access_size == SIZE_WORD) &&
                (int'(w.byte_offset) + int'(w.access_size) <= REGION_BYTES);
        case (w.cmd)
            CMD_REGION_WR: begin
                if (legal) begin
                    for (int i = 0; i < int'(w.access_size); i++) begin
                        pos = int'(w.byte_offset) + i;
                        region_words[pos / 4][(pos % 4) * 8 +: 8] = w.write_data[i * 8 +: 8];
                    end
                    r.accepted = 1'b1;
                end
            end
            CMD_REGION_RD: begin
                if (legal) begin
                    for (int i = 0; i < int'(w.access_size); i++) begin
                        pos = int'(w.byte_offset) + i;
                        r.read_data[i * 8 +: 8] = region_words[pos / 4][(pos % 4) * 8 +: 8];
                    end
                    r.accepted = 1'b1;
                end
            end
            CMD_DOORBELL_WR: begin
                if (w.access_size == SIZE_WORD) begin
                    target = 32'(w.write_data[23:16]);
                    if (target == 0) target = worker_for({16'h0, w.write_data[15:0]});
                    target = post_work(target, {16'h0, w.write_data[15:0]});
                    r.accepted = 1'b1;
                end
            end
            CMD_DOORBELL_RD: begin
                r.read_data = region_words[W_DONE];
                r.accepted = 1'b1;
            end
            CMD_COUNTER_ST: begin
                r.accepted = 1'b1;
                if (w.source_hart == 3'd0 && live_harts() >= 2)
                    target = post_work(worker_for(w.write_data), w.write_data);
            end
            CMD_INIT: begin
                for (int k = 0; k < REGION_WORDS; k++) region_words[k] = 32'h0;
                region_words[W_NHARTS] = {28'h0, harts_cfg};
                r.accepted = 1'b1;
            end
            default: ;
        endcase
        r.ipi_sent = (target != 0);
        r.ipi_target = target[2:0];
        return r;
    endfunction

    function automatic t_out_word outcome(logic [31:0] rd, logic acc, logic ipi, logic [2:0] tgt);
        t_out_word r;
        r.read_data = rd;
        r.accepted = acc;
        r.ipi_sent = ipi;
        r.ipi_target = tgt;
        return r;
    endfunction

    function automatic t_stim_row row(logic [2:0] cmd, logic [5:0] off, logic [2:0] size,
                                      logic [31:0] data, logic [2:0] src, bit typed,
                                      t_out_word res);
        t_stim_row r;
        r = '0;
        r.word.cmd = cmd;
        r.word.byte_offset = off;
        r.word.access_size = size;
        r.word.write_data = data;
        r.word.source_hart = src;
        r.typed = typed;
        r.result = res;
        return r;
    endfunction

    function automatic t_in_word random_word();
        t_in_word    w;
        int unsigned pick;
        w.byte_offset = 6'($urandom_range(0, 63));
        case ($urandom_range(0, 2))
            0: w.access_size = SIZE_BYTE;
            1: w.access_size = SIZE_HALF;
            default: w.access_size = SIZE_WORD;
        endcase
        if ($urandom_range(0, 9) == 0) w.access_size = $urandom_range(0, 1) ? SIZE_NONE : SIZE_ODD;
        w.write_data = $urandom();
        w.source_hart = 3'($urandom_range(0, 7));
        pick = $urandom_range(0, 99);
        if (pick < 26) begin
            w.cmd = CMD_REGION_WR;
        end else if (pick < 52) begin
            w.cmd = CMD_REGION_RD;
        end else if (pick < 68) begin
            w.cmd = CMD_DOORBELL_WR;
            if ($urandom_range(0, 9) != 0) w.access_size = SIZE_WORD;
            case ($urandom_range(0, 3))
                0, 1: w.write_data[23:16] = 8'h00;
                2: w.write_data[23:16] = 8'($urandom_range(1, 8));
                default: ;
            endcase
        end else if (pick < 75) begin
            w.cmd = CMD_DOORBELL_RD;
        end else if (pick < 92) begin
            w.cmd = CMD_COUNTER_ST;
            if ($urandom_range(0, 2) != 0) w.source_hart = 3'd0;
            if ($urandom_range(0, 1) == 0) w.write_data = $urandom_range(0, 20);
        end else if (pick < 97) begin
            w.cmd = CMD_INIT;
        end else begin
            w.cmd = $urandom_range(0, 1) ? CMD_RSVD_6 : CMD_RSVD_7;
        end
        return w;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("%0t: %s expected %h got %h", $time, name, want, got);
        end
    endtask

    task automatic send_word(t_in_word w, bit typed, t_out_word res);
        @(negedge i_clk);
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word <= w;
        row_typed = typed;
        row_result = res;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (due_words.size() != 0) @(negedge i_clk);
    endtask

    task automatic load_hart_count(logic [3:0] h);
        settle();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= h;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        harts_cfg = h;
    endtask

    // result side: random stall bursts, one long hold-off on request, none once no_idle is set
    always @(negedge i_clk) begin
        if (long_hold_req) begin
            long_hold_req = 1'b0;
            stall_left = LONG_HOLD;
        end else if (no_idle) begin
            stall_left = 0;
        end else if (stall_left == 0 && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 13);
        end
        i_out_stall <= (stall_left != 0);
        if (stall_left != 0) stall_left--;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            quiet_cycles++;
            if (o_out_valid && !i_out_stall) begin
                quiet_cycles = 0;
                if (due_words.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t: result expected none got %h", $time, o_out_word);
                end else begin
                    due = due_words.pop_front();
                    check_field("read_data", due.read_data, o_out_word.read_data);
                    check_field("accepted", 32'(due.accepted), 32'(o_out_word.accepted));
                    check_field("ipi_sent", 32'(due.ipi_sent), 32'(o_out_word.ipi_sent));
                    check_field("ipi_target", 32'(due.ipi_target),
                                32'(o_out_word.ipi_target));
                end
            end
            if (i_in_valid && !o_in_stall) begin
                quiet_cycles = 0;
                due = mailbox_step(i_in_word);
                due_words.push_back(row_typed ? row_result : due);
            end
        end
    end

    initial begin
        wait (quiet_cycles >= STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        t_stim_row cfg_row;
        for (int k = 0; k < REGION_WORDS; k++) region_words[k] = 32'h0;
        harts_cfg = 4'd1;
        phase_harts = '{4'd2, 4'd8, 4'd1, 4'd5, 4'd3, 4'd7, 4'd8};

        // single hart after reset: bounds, sizes, unknown commands, no workers
        directed.push_back(row(CMD_DOORBELL_RD, 6'd0, SIZE_NONE, 32'h0, 3'd0, 1,
                               outcome(32'h0, 1'b1, 1'b0, 3'd0)));
        directed.push_back(row(CMD_REGION_RD, 6'd0, SIZE_WORD, 32'h0, 3'd0, 1,
                               outcome(32'h0, 1'b1, 1'b0, 3'd0)));
        directed.push_back(row(CMD_REGION_RD, 6'd0, SIZE_ODD, 32'h0, 3'd0, 1,
                               outcome(32'h0, 1'b0, 1'b0, 3'd0)));
        directed.push_back(row(CMD_REGION_WR, 6'd61, SIZE_WORD, 32'hffff_ffff, 3'd0, 1,
                               outcome(32'h0, 1'b0, 1'b0, 3'd0)));
        directed.push_back(row(CMD_REGION_WR, 6'd60, SIZE_WORD, 32'hffff_ffff, 3'd7, 1,
                               outcome(32'h0, 1'b1, 1'b0, 3'd0)));
        directed.push_back(row(CMD_REGION_RD, 6'd63, SIZE_BYTE, 32'h0, 3'd0, 1,
                               outcome(32'h0000_00ff, 1'b1, 1'b0, 3'd0)));
        directed.push_back(row(CMD_REGION_RD, 6'd62, SIZE_HALF, 32'h0, 3'd0, 1,
                               outcome(32'h0000_ffff, 1'b1, 1'b0, 3'd0)));
        directed.push_back(row(CMD_RSVD_6, 6'd0, SIZE_WORD, 32'hffff_ffff, 3'd0, 1,
                               outcome(32'h0, 1'b0, 1'b0, 3'd0)));
        directed.push_back(row(CMD_RSVD_7, 6'd63, SIZE_WORD, 32'h0, 3'd7, 1,
                               outcome(32'h0, 1'b0, 1'b0, 3'd0)));
        directed.push_back(row(CMD_DOORBELL_WR, 6'd0, SIZE_HALF, 32'h0003_0005, 3'd0, 1,
                               outcome(32'h0, 1'b0, 1'b0, 3'd0)));
        directed.push_back(row(CMD_DOORBELL_WR, 6'd0, SIZE_WORD, 32'h0, 3'd0, 1,
                               outcome(32'h0, 1'b1, 1'b0, 3'd0)));
        directed.push_back(row(CMD_COUNTER_ST, 6'd0, SIZE_WORD, 32'd5, 3'd0, 1,
                               outcome(32'h0, 1'b1, 1'b0, 3'd0)));
        directed.push_back(row(CMD_INIT, 6'd0, SIZE_NONE, 32'h0, 3'd0, 1,
                               outcome(32'h0, 1'b1, 1'b0, 3'd0)));
        directed.push_back(row(CMD_REGION_RD, 6'd16, SIZE_WORD, 32'h0, 3'd0, 1,
                               outcome(32'h1, 1'b1, 1'b0, 3'd0)));
        cfg_row = '0;
        cfg_row.set_harts = 1'b1;
        cfg_row.harts = 4'd8;
        directed.push_back(cfg_row);
        // eight harts: explicit and round-robin targets, out-of-range targets
        directed.push_back(row(CMD_DOORBELL_WR, 6'd0, SIZE_WORD, 32'h0007_abcd, 3'd0, 1,
                               outcome(32'h0, 1'b1, 1'b1, 3'd7)));
        directed.push_back(row(CMD_DOORBELL_WR, 6'd0, SIZE_WORD, 32'h0008_0001, 3'd0, 1,
                               outcome(32'h0, 1'b1, 1'b0, 3'd0)));
        directed.push_back(row(CMD_DOORBELL_WR, 6'd0, SIZE_WORD, 32'h00ff_0000, 3'd0, 1,
                               outcome(32'h0, 1'b1, 1'b0, 3'd0)));
        directed.push_back(row(CMD_DOORBELL_WR, 6'd0, SIZE_WORD, 32'hff00_ffff, 3'd0, 0, '0));
        directed.push_back(row(CMD_COUNTER_ST, 6'd0, SIZE_WORD, 32'hffff_ffff, 3'd0, 0, '0));
        directed.push_back(row(CMD_COUNTER_ST, 6'd0, SIZE_WORD, 32'h1234_5678, 3'd7, 1,
                               outcome(32'h0, 1'b1, 1'b0, 3'd0)));
        directed.push_back(row(CMD_REGION_RD, 6'd4, SIZE_WORD, 32'h0, 3'd0, 0, '0));
        directed.push_back(row(CMD_REGION_WR, 6'd13, SIZE_WORD, 32'h1234_5678, 3'd0, 0, '0));
        directed.push_back(row(CMD_DOORBELL_RD, 6'd63, SIZE_NONE, 32'h0, 3'd0, 0, '0));
        directed.push_back(row(CMD_REGION_WR, 6'd33, SIZE_HALF, 32'ha5a5_beef, 3'd0, 0, '0));
        directed.push_back(row(CMD_REGION_RD, 6'd32, SIZE_WORD, 32'h0, 3'd0, 0, '0));

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[k]) begin
            if (directed[k].set_harts)
                load_hart_count(directed[k].harts);
            else
                send_word(directed[k].word, directed[k].typed, directed[k].result);
        end

        for (int p = 0; p < PHASES; p++) begin
            load_hart_count(phase_harts[p]);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (p == 1 && n == 30) long_hold_req = 1'b1;
                if (p == PHASES - 1 && n == ITEMS_PER_PHASE - 40) no_idle = 1'b1;
                send_word(random_word(), 1'b0, '0);
            end
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && due_words.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/ipimb_pkg.sv
hw/rtl/ipi_mailbox_sync_region.sv
dv/ipi_mailbox_sync_region_tb.sv
